// ===== src/wsrd_pkg.sv =====
// Shared constants, register codes and handshake structs of the silence range detector.
package wsrd_pkg;

    localparam int SAMPLE_BITS_DEF   = 16;
    localparam int WINDOW_BITS_DEF   = 16;
    localparam int POSITION_BITS_DEF = 48;

    localparam int OUT_POS_BITS  = 48;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 48;
    localparam int RUN_LEN_BITS  = 24;
    localparam int THR_BITS      = 16;
    localparam int CHAN_BITS     = 2;

    localparam int OUT_FIFO_DEPTH    = 8;
    localparam int OUT_FIFO_CNT_BITS = $clog2(OUT_FIFO_DEPTH + 1);

    localparam int WIN_LEN_RESET   = 480;
    localparam int MIN_LEN_RESET   = 24000;
    localparam int MERGE_GAP_RESET = 4800;
    localparam int RMS_THR_RESET   = 328;
    localparam int PEAK_THR_RESET  = 1638;
    localparam int CHAN_RESET      = 1;
    localparam int START_POS_RESET = 0;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_WINDOW_LENGTH  = 3'd0,
        CFG_MIN_SILENCE    = 3'd1,
        CFG_MERGE_GAP      = 3'd2,
        CFG_RMS_THRESHOLD  = 3'd3,
        CFG_PEAK_THRESHOLD = 3'd4,
        CFG_CHANNEL_COUNT  = 3'd5,
        CFG_START_POSITION = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic valid;
        logic finish;
    } t_frame_ctl;

    typedef struct packed {
        logic valid;
        logic close;
        logic finish;
    } t_event;

    typedef struct packed {
        logic [OUT_POS_BITS-1:0] range_end;
        logic [OUT_POS_BITS-1:0] range_start;
        logic                    range_valid;
        logic                    last;
    } t_result;

endpackage

// ===== src/windowed_silence_range_detector.sv =====
// Top level of the windowed silence range detector.
//
// Usage: s_axis carries one audio frame per word (left and right sample in
// tdata, tuser[0] = 0) or a finish command (tuser[0] = 1). m_axis carries
// silent ranges: tdata holds start and end position, tuser[0] says the word
// holds a range, tlast marks the final word caused by finish. The user must
// write registers on the cfg channel (index, data) only while the stream is
// idle; the block does not enforce this. Throughput: one frame per cycle
// while s_axis_tready stays high. A frame passes an input register, a square
// stage, the window accumulator, the limit multiplier and the verdict/run
// stage, which writes a range produced at a window close into the result
// FIFO for m_axis. Finish produces at most two words, the last one written by
// the finish flush that follows the verdict. Words queue in an 8-entry result
// FIFO; s_axis_tready drops while queued words plus items in flight could
// overrun it, so a stalled receiver halts intake and nothing is lost. After
// finish all further words on s_axis are taken and ignored until reset.
// Reset (synchronous, active low) restores the register defaults and clears
// all window, run and queue state; there is no clearing pass.
module windowed_silence_range_detector
    import wsrd_pkg::*;
#(
    parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
    parameter int WINDOW_BITS   = WINDOW_BITS_DEF,
    parameter int POSITION_BITS = POSITION_BITS_DEF,
    localparam int IN_DATA_BITS = ((2 * SAMPLE_BITS + 7) / 8) * 8,
    localparam int OUT_DATA_BITS = 2 * OUT_POS_BITS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,

    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [IN_DATA_BITS-1:0]  s_axis_tdata,   // left_sample, right_sample
    input  logic [0:0]               s_axis_tuser,   // command

    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    output logic [OUT_DATA_BITS-1:0] m_axis_tdata,   // range_start, range_end
    output logic [0:0]               m_axis_tuser,   // range_valid
    output logic                     m_axis_tlast,

    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    localparam int ENERGY_BITS    = 2 * SAMPLE_BITS + WINDOW_BITS + 1;
    localparam int CREDIT_BITS    = OUT_FIFO_CNT_BITS + 1;
    localparam int CREDIT_RESERVE = 3;

    logic [WINDOW_BITS-1:0]   r_win_len;
    logic [RUN_LEN_BITS-1:0]  r_min_len;
    logic [RUN_LEN_BITS-1:0]  r_merge_gap;
    logic [THR_BITS-1:0]      r_rms_thr;
    logic [THR_BITS-1:0]      r_peak_thr;
    logic [CHAN_BITS-1:0]     r_chan;
    logic                     r_started;

    logic                     take;
    logic                     cfg_wr;
    logic                     pos_load;
    logic                     stereo;

    t_frame_ctl               frame;
    logic [2*SAMPLE_BITS:0]   frame_energy;
    logic [SAMPLE_BITS-1:0]   frame_mag;
    logic [1:0]               front_busy;

    t_event                   win_event;
    logic [ENERGY_BITS-1:0]   win_energy;
    logic [SAMPLE_BITS-1:0]   win_peak;
    logic [WINDOW_BITS-1:0]   win_count;
    logic [POSITION_BITS-1:0] win_begin;
    logic [POSITION_BITS-1:0] win_end;

    logic [1:0]               wr_en;
    t_result                  res0;
    t_result                  res1;
    logic [1:0]               judge_busy;

    t_result                  out_word;
    logic [OUT_FIFO_CNT_BITS-1:0] fifo_count;
    logic [2:0]               busy;
    logic [CREDIT_BITS-1:0]   need;

    assign stereo   = r_chan[1];
    assign cfg_wr   = i_cfg_valid && o_cfg_ready;
    assign take     = s_axis_tvalid && s_axis_tready;
    assign pos_load = cfg_wr && !r_started
                      && (t_cfg_idx'(i_cfg_index) == CFG_START_POSITION);

    // hold intake while the queue could not absorb everything in flight
    always_comb begin
        busy = 3'(front_busy) + 3'(win_event.valid) + 3'(judge_busy);
        need = CREDIT_BITS'(fifo_count) + CREDIT_BITS'(busy) + CREDIT_BITS'(CREDIT_RESERVE);
        s_axis_tready = (need <= CREDIT_BITS'(OUT_FIFO_DEPTH));
    end

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_len   <= WINDOW_BITS'(WIN_LEN_RESET);
            r_min_len   <= RUN_LEN_BITS'(MIN_LEN_RESET);
            r_merge_gap <= RUN_LEN_BITS'(MERGE_GAP_RESET);
            r_rms_thr   <= THR_BITS'(RMS_THR_RESET);
            r_peak_thr  <= THR_BITS'(PEAK_THR_RESET);
            r_chan      <= CHAN_BITS'(CHAN_RESET);
            r_started   <= 1'b0;
        end else begin
            if (take && !s_axis_tuser[0]) begin
                r_started <= 1'b1;
            end
            if (cfg_wr) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_WINDOW_LENGTH:  r_win_len   <= i_cfg_data[WINDOW_BITS-1:0];
                    CFG_MIN_SILENCE:    r_min_len   <= i_cfg_data[RUN_LEN_BITS-1:0];
                    CFG_MERGE_GAP:      r_merge_gap <= i_cfg_data[RUN_LEN_BITS-1:0];
                    CFG_RMS_THRESHOLD:  r_rms_thr   <= i_cfg_data[THR_BITS-1:0];
                    CFG_PEAK_THRESHOLD: r_peak_thr  <= i_cfg_data[THR_BITS-1:0];
                    CFG_CHANNEL_COUNT:  r_chan      <= i_cfg_data[CHAN_BITS-1:0];
                    // start position only loads the timeline in the window stage
                    CFG_START_POSITION: ;
                    default: ;
                endcase
            end
        end
    end

    wsrd_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_take    (take),
        .i_command (s_axis_tuser[0]),
        .i_left    (s_axis_tdata[SAMPLE_BITS-1:0]),
        .i_right   (s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
        .i_stereo  (stereo),
        .o_frame   (frame),
        .o_energy  (frame_energy),
        .o_mag     (frame_mag),
        .o_busy    (front_busy)
    );

    wsrd_window #(
        .SAMPLE_BITS   (SAMPLE_BITS),
        .WINDOW_BITS   (WINDOW_BITS),
        .POSITION_BITS (POSITION_BITS)
    ) u_window (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_frame     (frame),
        .i_energy    (frame_energy),
        .i_mag       (frame_mag),
        .i_win_len   (r_win_len),
        .i_pos_load  (pos_load),
        .i_pos_value (POSITION_BITS'(i_cfg_data)),
        .o_event     (win_event),
        .o_energy    (win_energy),
        .o_peak      (win_peak),
        .o_count     (win_count),
        .o_begin     (win_begin),
        .o_end       (win_end)
    );

    wsrd_judge #(
        .SAMPLE_BITS   (SAMPLE_BITS),
        .WINDOW_BITS   (WINDOW_BITS),
        .POSITION_BITS (POSITION_BITS)
    ) u_judge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_event     (win_event),
        .i_energy    (win_energy),
        .i_peak      (win_peak),
        .i_count     (win_count),
        .i_begin     (win_begin),
        .i_end       (win_end),
        .i_rms_thr   (r_rms_thr),
        .i_peak_thr  (r_peak_thr),
        .i_stereo    (stereo),
        .i_min_len   (r_min_len),
        .i_merge_gap (r_merge_gap),
        .o_wr_en     (wr_en),
        .o_res0      (res0),
        .o_res1      (res1),
        .o_busy      (judge_busy)
    );

    wsrd_out_fifo u_out_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (wr_en),
        .i_wr_data0 (res0),
        .i_wr_data1 (res1),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_data     (out_word),
        .o_count    (fifo_count)
    );

    assign m_axis_tdata = {out_word.range_end, out_word.range_start};
    assign m_axis_tuser = out_word.range_valid;
    assign m_axis_tlast = out_word.last;

endmodule

// ===== src/wsrd_front.sv =====
// Input register and per-frame magnitude and square stage.
module wsrd_front
    import wsrd_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_take,
    input  logic                          i_command,
    input  logic signed [SAMPLE_BITS-1:0] i_left,
    input  logic signed [SAMPLE_BITS-1:0] i_right,
    input  logic                          i_stereo,
    output t_frame_ctl                    o_frame,
    output logic [2*SAMPLE_BITS:0]        o_energy,
    output logic [SAMPLE_BITS-1:0]        o_mag,
    output logic [1:0]                    o_busy
);

    function automatic logic [SAMPLE_BITS-1:0] magnitude(input logic [SAMPLE_BITS-1:0] v);
        return v[SAMPLE_BITS-1] ? (~v + 1'b1) : v;
    endfunction

    logic                          r_v0;
    logic                          r_cmd0;
    logic signed [SAMPLE_BITS-1:0] r_left0;
    logic signed [SAMPLE_BITS-1:0] r_right0;

    t_frame_ctl                    r_frame1;
    logic [2*SAMPLE_BITS:0]        r_sq1;
    logic [SAMPLE_BITS-1:0]        r_mag1;

    logic [SAMPLE_BITS-1:0]        mag_l;
    logic [SAMPLE_BITS-1:0]        mag_r;
    logic [2*SAMPLE_BITS-1:0]      sq_l;
    logic [2*SAMPLE_BITS-1:0]      sq_r;
    logic [2*SAMPLE_BITS:0]        n_sq;
    logic [SAMPLE_BITS-1:0]        n_mag;

    always_comb begin
        mag_l = magnitude($unsigned(r_left0));
        mag_r = magnitude($unsigned(r_right0));
        sq_l  = mag_l * mag_l;
        sq_r  = mag_r * mag_r;
        // right channel counts only in stereo
        n_sq  = {1'b0, sq_l} + (i_stereo ? {1'b0, sq_r} : '0);
        n_mag = (i_stereo && (mag_r > mag_l)) ? mag_r : mag_l;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0     <= 1'b0;
            r_frame1 <= '0;
        end else begin
            r_v0            <= i_take;
            r_frame1.valid  <= r_v0;
            r_frame1.finish <= r_cmd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_cmd0   <= i_command;
            r_left0  <= i_left;
            r_right0 <= i_right;
        end
        r_sq1  <= n_sq;
        r_mag1 <= n_mag;
    end

    assign o_frame  = r_frame1;
    assign o_energy = r_sq1;
    assign o_mag    = r_mag1;
    assign o_busy   = {1'b0, r_v0} + {1'b0, r_frame1.valid};

endmodule

// ===== src/wsrd_window.sv =====
// Window accumulator: energy, peak, frame count and timeline position.
module wsrd_window
    import wsrd_pkg::*;
#(
    parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
    parameter int WINDOW_BITS   = WINDOW_BITS_DEF,
    parameter int POSITION_BITS = POSITION_BITS_DEF,
    localparam int ENERGY_BITS  = 2 * SAMPLE_BITS + WINDOW_BITS + 1
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_frame_ctl               i_frame,
    input  logic [2*SAMPLE_BITS:0]   i_energy,
    input  logic [SAMPLE_BITS-1:0]   i_mag,
    input  logic [WINDOW_BITS-1:0]   i_win_len,
    input  logic                     i_pos_load,
    input  logic [POSITION_BITS-1:0] i_pos_value,
    output t_event                   o_event,
    output logic [ENERGY_BITS-1:0]   o_energy,
    output logic [SAMPLE_BITS-1:0]   o_peak,
    output logic [WINDOW_BITS-1:0]   o_count,
    output logic [POSITION_BITS-1:0] o_begin,
    output logic [POSITION_BITS-1:0] o_end
);

    logic                     r_done;
    logic [WINDOW_BITS-1:0]   r_count;
    logic [ENERGY_BITS-1:0]   r_energy;
    logic [SAMPLE_BITS-1:0]   r_peak;
    logic [POSITION_BITS-1:0] r_begin;
    logic [POSITION_BITS-1:0] r_pos;

    logic                     n_done;
    logic [WINDOW_BITS-1:0]   n_count;
    logic [ENERGY_BITS-1:0]   n_energy;
    logic [SAMPLE_BITS-1:0]   n_peak;
    logic [POSITION_BITS-1:0] n_begin;
    logic [POSITION_BITS-1:0] n_pos;

    t_event                   r_ev;
    logic [ENERGY_BITS-1:0]   r_rec_energy;
    logic [SAMPLE_BITS-1:0]   r_rec_peak;
    logic [WINDOW_BITS-1:0]   r_rec_count;
    logic [POSITION_BITS-1:0] r_rec_begin;
    logic [POSITION_BITS-1:0] r_rec_end;

    t_event                   n_ev;
    logic [ENERGY_BITS-1:0]   n_rec_energy;
    logic [SAMPLE_BITS-1:0]   n_rec_peak;
    logic [WINDOW_BITS-1:0]   n_rec_count;
    logic [POSITION_BITS-1:0] n_rec_begin;
    logic [POSITION_BITS-1:0] n_rec_end;

    logic [WINDOW_BITS-1:0]   len_eff;
    logic [WINDOW_BITS-1:0]   cnt_inc;
    logic [ENERGY_BITS-1:0]   energy_acc;
    logic [SAMPLE_BITS-1:0]   peak_acc;
    logic [POSITION_BITS-1:0] pos_inc;

    always_comb begin
        len_eff    = (i_win_len == '0) ? WINDOW_BITS'(1) : i_win_len;
        cnt_inc    = r_count + 1'b1;
        energy_acc = r_energy + ENERGY_BITS'(i_energy);
        peak_acc   = (i_mag > r_peak) ? i_mag : r_peak;
        pos_inc    = r_pos + 1'b1;

        n_done       = r_done;
        n_count      = r_count;
        n_energy     = r_energy;
        n_peak       = r_peak;
        n_begin      = r_begin;
        n_pos        = r_pos;
        n_ev         = '0;
        n_rec_energy = energy_acc;
        n_rec_peak   = peak_acc;
        n_rec_count  = cnt_inc;
        n_rec_begin  = r_begin;
        n_rec_end    = pos_inc;

        if (i_frame.valid && !r_done) begin
            if (!i_frame.finish) begin
                n_pos = pos_inc;
                if (cnt_inc >= len_eff) begin
                    n_ev.valid = 1'b1;
                    n_ev.close = 1'b1;
                    n_count    = '0;
                    n_energy   = '0;
                    n_peak     = '0;
                    n_begin    = pos_inc;
                end else begin
                    n_count  = cnt_inc;
                    n_energy = energy_acc;
                    n_peak   = peak_acc;
                end
            end else begin
                // close the partial window, if any, then flush downstream
                n_done       = 1'b1;
                n_ev.valid   = 1'b1;
                n_ev.close   = (r_count != '0);
                n_ev.finish  = 1'b1;
                n_rec_energy = r_energy;
                n_rec_peak   = r_peak;
                n_rec_count  = r_count;
                n_rec_end    = r_pos;
                n_count      = '0;
                n_energy     = '0;
                n_peak       = '0;
            end
        end

        if (i_pos_load) begin
            n_pos   = i_pos_value;
            n_begin = i_pos_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done   <= 1'b0;
            r_count  <= '0;
            r_energy <= '0;
            r_peak   <= '0;
            r_begin  <= POSITION_BITS'(START_POS_RESET);
            r_pos    <= POSITION_BITS'(START_POS_RESET);
            r_ev     <= '0;
        end else begin
            r_done   <= n_done;
            r_count  <= n_count;
            r_energy <= n_energy;
            r_peak   <= n_peak;
            r_begin  <= n_begin;
            r_pos    <= n_pos;
            r_ev     <= n_ev;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rec_energy <= n_rec_energy;
        r_rec_peak   <= n_rec_peak;
        r_rec_count  <= n_rec_count;
        r_rec_begin  <= n_rec_begin;
        r_rec_end    <= n_rec_end;
    end

    assign o_event  = r_ev;
    assign o_energy = r_rec_energy;
    assign o_peak   = r_rec_peak;
    assign o_count  = r_rec_count;
    assign o_begin  = r_rec_begin;
    assign o_end    = r_rec_end;

    a_done_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> r_done)
        else $error("stream done flag dropped without reset");

    a_close_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_event.valid && o_event.close) |-> (o_count != '0))
        else $error("window closed with no frames");

endmodule

// ===== src/wsrd_judge.sv =====
// Window verdict, run tracking, range merging and finish flush.
module wsrd_judge
    import wsrd_pkg::*;
#(
    parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
    parameter int WINDOW_BITS   = WINDOW_BITS_DEF,
    parameter int POSITION_BITS = POSITION_BITS_DEF,
    localparam int ENERGY_BITS  = 2 * SAMPLE_BITS + WINDOW_BITS + 1
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_event                   i_event,
    input  logic [ENERGY_BITS-1:0]   i_energy,
    input  logic [SAMPLE_BITS-1:0]   i_peak,
    input  logic [WINDOW_BITS-1:0]   i_count,
    input  logic [POSITION_BITS-1:0] i_begin,
    input  logic [POSITION_BITS-1:0] i_end,
    input  logic [THR_BITS-1:0]      i_rms_thr,
    input  logic [THR_BITS-1:0]      i_peak_thr,
    input  logic                     i_stereo,
    input  logic [RUN_LEN_BITS-1:0]  i_min_len,
    input  logic [RUN_LEN_BITS-1:0]  i_merge_gap,
    output logic [1:0]               o_wr_en,
    output t_result                  o_res0,
    output t_result                  o_res1,
    output logic [1:0]               o_busy
);

    localparam int PROD_BITS = 2 * THR_BITS + WINDOW_BITS;
    localparam int LIM_BITS  = PROD_BITS + 1;
    localparam int CMP_BITS  = (ENERGY_BITS > LIM_BITS) ? ENERGY_BITS : LIM_BITS;
    localparam int PK_BITS   = (SAMPLE_BITS > THR_BITS) ? SAMPLE_BITS : THR_BITS;

    logic [2*THR_BITS-1:0]    r_rms_sq;
    logic [PROD_BITS-1:0]     prod;
    logic [LIM_BITS-1:0]      limit;

    t_event                   r_ev3;
    logic [ENERGY_BITS-1:0]   r_energy3;
    logic [LIM_BITS-1:0]      r_limit3;
    logic                     r_peak_ok3;
    logic [POSITION_BITS-1:0] r_begin3;
    logic [POSITION_BITS-1:0] r_end3;

    logic                     r_run_active;
    logic [POSITION_BITS-1:0] r_run_begin;
    logic [POSITION_BITS-1:0] r_run_end;
    logic                     r_held_valid;
    logic [POSITION_BITS-1:0] r_held_begin;
    logic [POSITION_BITS-1:0] r_held_end;
    logic                     r_fin_pend;

    logic                     n_run_active;
    logic [POSITION_BITS-1:0] n_run_begin;
    logic [POSITION_BITS-1:0] n_run_end;
    logic                     n_held_valid;
    logic [POSITION_BITS-1:0] n_held_begin;
    logic [POSITION_BITS-1:0] n_held_end;
    logic                     n_fin_pend;

    logic [POSITION_BITS-1:0] run_len;
    logic [POSITION_BITS-1:0] held_gap;
    logic                     run_kept;
    logic                     gap_ok;
    logic                     silent;
    logic                     settle_emit;
    t_result                  held_res;
    t_result                  res_last;

    // stage 3: threshold limit for the closed window
    always_comb begin
        prod  = r_rms_sq * i_count;
        limit = i_stereo ? {prod, 1'b0} : {1'b0, prod};
    end

    always_ff @(posedge i_clk) begin
        r_rms_sq   <= i_rms_thr * i_rms_thr;
        r_energy3  <= i_energy;
        r_limit3   <= limit;
        r_peak_ok3 <= (PK_BITS'(i_peak) <= PK_BITS'(i_peak_thr));
        r_begin3   <= i_begin;
        r_end3     <= i_end;
    end

    // stage 4 (window verdict), and the finish flush in the cycle after
    always_comb begin
        run_len  = r_run_end - r_run_begin;
        held_gap = r_run_begin - r_held_end;
        run_kept = (run_len >= POSITION_BITS'(i_min_len));
        gap_ok   = (held_gap <= POSITION_BITS'(i_merge_gap));
        silent   = (CMP_BITS'(r_energy3) <= CMP_BITS'(r_limit3)) && r_peak_ok3;

        held_res.range_start = OUT_POS_BITS'(r_held_begin);
        held_res.range_end   = OUT_POS_BITS'(r_held_end);
        held_res.range_valid = 1'b1;
        held_res.last        = 1'b0;

        n_run_active = r_run_active;
        n_run_begin  = r_run_begin;
        n_run_end    = r_run_end;
        n_held_valid = r_held_valid;
        n_held_begin = r_held_begin;
        n_held_end   = r_held_end;
        n_fin_pend   = r_fin_pend;
        settle_emit  = 1'b0;
        res_last     = '0;
        o_wr_en      = 2'b00;
        o_res0       = held_res;
        o_res1       = '0;

        if (r_fin_pend) begin
            n_fin_pend = 1'b0;
            if (r_run_active && run_kept) begin
                if (r_held_valid && gap_ok) begin
                    n_held_end = r_run_end;
                end else begin
                    settle_emit  = r_held_valid;
                    n_held_begin = r_run_begin;
                    n_held_end   = r_run_end;
                    n_held_valid = 1'b1;
                end
            end
            n_run_active = 1'b0;

            res_last.last = 1'b1;
            if (n_held_valid) begin
                res_last.range_start = OUT_POS_BITS'(n_held_begin);
                res_last.range_end   = OUT_POS_BITS'(n_held_end);
                res_last.range_valid = 1'b1;
            end
            n_held_valid = 1'b0;

            if (settle_emit) begin
                o_wr_en = 2'b11;
                o_res1  = res_last;
            end else begin
                o_wr_en = 2'b01;
                o_res0  = res_last;
            end
        end else if (r_ev3.valid) begin
            if (r_ev3.close) begin
                if (silent) begin
                    if (r_run_active && (r_run_end == r_begin3)) begin
                        n_run_end = r_end3;
                    end else begin
                        // a kept run cut short replaces the held range quietly
                        if (r_run_active && run_kept) begin
                            n_held_begin = r_run_begin;
                            n_held_end   = r_run_end;
                            n_held_valid = 1'b1;
                        end
                        n_run_begin  = r_begin3;
                        n_run_end    = r_end3;
                        n_run_active = 1'b1;
                    end
                end else if (r_run_active) begin
                    if (run_kept) begin
                        if (r_held_valid && gap_ok) begin
                            n_held_end = r_run_end;
                        end else begin
                            o_wr_en[0]   = r_held_valid;
                            n_held_begin = r_run_begin;
                            n_held_end   = r_run_end;
                            n_held_valid = 1'b1;
                        end
                    end
                    n_run_active = 1'b0;
                end
            end
            if (r_ev3.finish) begin
                n_fin_pend = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ev3        <= '0;
            r_run_active <= 1'b0;
            r_held_valid <= 1'b0;
            r_fin_pend   <= 1'b0;
        end else begin
            r_ev3        <= i_event;
            r_run_active <= n_run_active;
            r_held_valid <= n_held_valid;
            r_fin_pend   <= n_fin_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_run_begin  <= n_run_begin;
        r_run_end    <= n_run_end;
        r_held_begin <= n_held_begin;
        r_held_end   <= n_held_end;
    end

    assign o_busy = {1'b0, r_ev3.valid} + {1'b0, r_fin_pend};

    a_flush_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fin_pend |-> !r_ev3.valid)
        else $error("window event arrived behind finish");

    a_flush_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fin_pend |=> !r_fin_pend)
        else $error("finish flush repeated");

endmodule

// ===== src/wsrd_out_fifo.sv =====
// Result queue with two write lanes and one read port.
module wsrd_out_fifo
    import wsrd_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [1:0]                   i_wr_en,
    input  t_result                      i_wr_data0,
    input  t_result                      i_wr_data1,
    output logic                         o_valid,
    input  logic                         i_ready,
    output t_result                      o_data,
    output logic [OUT_FIFO_CNT_BITS-1:0] o_count
);

    localparam int PTR_BITS = $clog2(OUT_FIFO_DEPTH);

    t_result                      r_mem [OUT_FIFO_DEPTH];
    logic [PTR_BITS-1:0]          r_wr_ptr;
    logic [PTR_BITS-1:0]          r_rd_ptr;
    logic [OUT_FIFO_CNT_BITS-1:0] r_count;

    logic [PTR_BITS-1:0]          wr_ptr1;
    logic [OUT_FIFO_CNT_BITS-1:0] wr_num;
    logic                         rd;

    always_comb begin
        wr_ptr1 = r_wr_ptr + 1'b1;
        wr_num  = OUT_FIFO_CNT_BITS'(i_wr_en[0]) + OUT_FIFO_CNT_BITS'(i_wr_en[1]);
        rd      = o_valid && i_ready;
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en[0]) begin
            r_mem[r_wr_ptr] <= i_wr_data0;
        end
        if (i_wr_en[1]) begin
            r_mem[wr_ptr1] <= i_wr_data1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + PTR_BITS'(wr_num);
            r_rd_ptr <= r_rd_ptr + PTR_BITS'(rd);
            r_count  <= r_count + wr_num - OUT_FIFO_CNT_BITS'(rd);
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_num != '0) |-> ((r_count + wr_num) <= OUT_FIFO_CNT_BITS'(OUT_FIFO_DEPTH)))
        else $error("result queue overflow");

    a_lane_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr_en[1] |-> i_wr_en[0])
        else $error("second write lane used alone");

endmodule
